// ----- rtl/core/fmso_pkg.sv -----
// Shared types and constants of the FM sine operator.
// Used by every module of the block; depends on nothing else.
package fmso_pkg;

  localparam int PHASE_W           = 32;
  localparam int SAMPLE_W          = 16;
  localparam int ANGLE_TABLE_SIZE  = 24;
  localparam int SINE_ITERATIONS_DEF = 16;

  // CORDIC datapath width: the vector length stays close to 2^30.
  localparam int XY_W = 33;

  // 1/(2*pi) as an unsigned Q0.32 fraction; it fits in 30 bits.
  localparam int INV_W = 30;
  localparam logic [INV_W-1:0] INV_TWO_PI_Q32 = 30'd683565276;

  // Start value of x: the CORDIC gain K in Q2.30.
  localparam logic signed [XY_W-1:0] CORDIC_GAIN_Q30 = 33'sd652032874;

  // Rotation angles in Q0.32 turns.
  localparam logic [PHASE_W-1:0] ATAN_TURNS [ANGLE_TABLE_SIZE] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  localparam logic [PHASE_W-1:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [PHASE_W-1:0] HALF_TURN    = 32'h8000_0000;
  localparam logic [PHASE_W-1:0] THREE_QUARTER_TURN = 32'hC000_0000;

  localparam logic signed [SAMPLE_W-1:0] SINE_MAX = 16'sd32767;
  localparam logic signed [SAMPLE_W-1:0] SINE_MIN = -16'sd32767;

  // Configuration register indexes; the last one selects no register.
  typedef enum logic [1:0] {
    REG_FM_ENABLE       = 2'd0,
    REG_FREQUENCY_RATIO = 2'd1,
    REG_MOD_INDEX       = 2'd2,
    REG_UNUSED          = 2'd3
  } fmso_reg_t;

  typedef struct packed {
    logic               fm_enable;
    logic [23:0]        frequency_ratio;
    logic signed [23:0] mod_index;
  } fmso_cfg_t;

  // One item on its way from the phase stages to the sine stages.
  typedef struct packed {
    logic               valid;
    logic               last;
    logic [PHASE_W-1:0] phase;
  } fmso_phase_t;

  // One finished result leaving the sine stages.
  typedef struct packed {
    logic                       valid;
    logic                       last;
    logic signed [SAMPLE_W-1:0] sine;
  } fmso_res_t;

endpackage

// ----- rtl/core/fmso_phase.sv -----
// Phase stages of the FM sine operator: four register stages that form the
// carrier phase and add the modulator term. Depends on fmso_pkg.
module fmso_phase
  import fmso_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  fmso_cfg_t          cfg,
  input  logic               in_valid,
  input  logic [31:0]        sample_time,
  input  logic [23:0]        base_frequency,
  input  logic signed [15:0] modulator_sample,
  input  logic               block_last,
  output fmso_phase_t        item
);

  // Stage 1: ratio * time, and index * modulator.
  logic [55:0]        rt_prod;
  logic [39:0]        rt1;
  logic signed [39:0] m1;
  logic [23:0]        f1;
  logic               v1, l1;

  // Stage 2: carrier partial products, modulator magnitude.
  logic [47:0] lo_prod;
  logic [39:0] hi_prod;
  logic [39:0] m_neg;
  logic [47:0] clo2;
  logic [15:0] chi2;
  logic [38:0] mag2;
  logic        neg2, v2, l2;

  // Stage 3: carrier phase, scaled modulator partial products.
  logic [52:0]        hp3;
  logic [45:0]        lp3;
  logic [PHASE_W-1:0] cph3;
  logic               neg3, v3, l3;

  // Stage 4: phase with the modulator term.
  logic [53:0]        term_sum;
  logic [PHASE_W-1:0] term_mag;
  logic [PHASE_W-1:0] term;
  logic [PHASE_W-1:0] phase4;
  logic               v4, l4;

  assign rt_prod = 56'(cfg.frequency_ratio) * 56'(sample_time);
  assign lo_prod = 48'(rt1[23:0]) * 48'(f1);
  assign hi_prod = 40'(rt1[39:24]) * 40'(f1);
  assign m_neg   = -m1;

  // The modulator term is truncated towards zero, so the magnitude is scaled
  // and the sign put back afterwards.
  assign term_sum = {1'b0, hp3} + {24'b0, lp3[45:16]};
  assign term_mag = term_sum[46:15];
  assign term     = neg3 ? (32'd0 - term_mag) : term_mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rt1  <= rt_prod[39:0];
      // With FM off the product is cleared, so the term added later is zero.
      m1   <= cfg.fm_enable ? 40'(cfg.mod_index) * 40'(modulator_sample) : 40'sd0;
      f1   <= base_frequency;
      l1   <= block_last;

      clo2 <= lo_prod;
      chi2 <= hi_prod[15:0];
      neg2 <= m1[39];
      mag2 <= m1[39] ? m_neg[38:0] : m1[38:0];
      l2   <= l1;

      // The upper partial product only reaches phase bits 16 and up.
      cph3 <= clo2[39:8] + {chi2, 16'h0000};
      hp3  <= 53'(mag2[38:16]) * 53'(INV_TWO_PI_Q32);
      lp3  <= 46'(mag2[15:0]) * 46'(INV_TWO_PI_Q32);
      neg3 <= neg2;
      l3   <= l2;

      phase4 <= cph3 + term;
      l4     <= l3;
    end
  end

  assign item.valid = v4;
  assign item.last  = l4;
  assign item.phase = phase4;

endmodule

// ----- rtl/core/fmso_cordic.sv -----
// Pipelined rotation-mode CORDIC of the FM sine operator: a folding stage,
// one stage per iteration, up to the size of the angle table, and a rounding stage. Depends on fmso_pkg.
module fmso_cordic
  import fmso_pkg::*;
#(
  parameter int ITERATIONS = SINE_ITERATIONS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  fmso_phase_t item,
  output fmso_res_t   res
);

  localparam int STAGES = (ITERATIONS > ANGLE_TABLE_SIZE) ? ANGLE_TABLE_SIZE : ITERATIONS;
  localparam int RND_W  = XY_W + 1 - 15;

  logic signed [XY_W-1:0] x [0:STAGES];
  logic signed [XY_W-1:0] y [0:STAGES];
  logic [PHASE_W-1:0]     z [0:STAGES];
  logic                   vld [0:STAGES];
  logic                   lst [0:STAGES];
  logic                   flp [0:STAGES];

  logic                   fold;
  logic signed [XY_W:0]   y_sum;
  logic signed [RND_W-1:0] rnd;
  logic signed [RND_W-1:0] rnd_signed;
  logic signed [SAMPLE_W-1:0] sat;
  logic                   out_vld;
  logic                   out_lst;
  logic signed [SAMPLE_W-1:0] out_sine;

  // Phases in the left half plane are turned by half a turn and the sign
  // of the result flipped.
  assign fold = (item.phase > QUARTER_TURN) && (item.phase < THREE_QUARTER_TURN);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x[0]   <= CORDIC_GAIN_Q30;
      y[0]   <= '0;
      z[0]   <= fold ? (item.phase - HALF_TURN) : item.phase;
      flp[0] <= fold;
      lst[0] <= item.last;
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_iter
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;

    assign dx = y[i] >>> i;
    assign dy = x[i] >>> i;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (!z[i][PHASE_W-1]) begin
          x[i+1] <= x[i] - dx;
          y[i+1] <= y[i] + dy;
          z[i+1] <= z[i] - ATAN_TURNS[i];
        end else begin
          x[i+1] <= x[i] + dx;
          y[i+1] <= y[i] - dy;
          z[i+1] <= z[i] + ATAN_TURNS[i];
        end
        flp[i+1] <= flp[i];
        lst[i+1] <= lst[i];
      end
    end
  end

  // Round Q2.30 to Q1.15 with the shift rounding towards minus infinity.
  assign y_sum      = {y[STAGES][XY_W-1], y[STAGES]} + (XY_W+1)'(16384);
  assign rnd        = RND_W'(y_sum >>> 15);
  assign rnd_signed = flp[STAGES] ? -rnd : rnd;

  always_comb begin
    if (rnd_signed > RND_W'(SINE_MAX)) begin
      sat = SINE_MAX;
    end else if (rnd_signed < RND_W'(SINE_MIN)) begin
      sat = SINE_MIN;
    end else begin
      sat = rnd_signed[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= vld[STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_sine <= sat;
      out_lst  <= lst[STAGES];
    end
  end

  assign res.valid = out_vld;
  assign res.last  = out_lst;
  assign res.sine  = out_sine;

endmodule

// ----- rtl/core/fmso_skid.sv -----
// Output register and skid register of the FM sine operator; they part the
// pipeline from the result channel. Depends on fmso_pkg.
module fmso_skid
  import fmso_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  fmso_res_t                  res,
  input  logic                       out_ready,
  output logic                       held,
  output logic                       out_valid,
  output logic signed [SAMPLE_W-1:0] sine_out,
  output logic                       last_out
);

  logic                       skid_valid;
  logic signed [SAMPLE_W-1:0] skid_sine;
  logic                       skid_last;
  logic                       out_free;

  assign out_free = !out_valid || out_ready;
  assign held     = skid_valid;

  // With the skid register empty the pipeline moves, and the item leaving
  // its last stage goes to the output register if that is free, otherwise
  // into the skid register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_free) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (out_free) begin
      out_valid <= res.valid;
    end else if (res.valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_free) begin
        sine_out <= skid_sine;
        last_out <= skid_last;
      end
    end else if (out_free) begin
      sine_out <= res.sine;
      last_out <= res.last;
    end else begin
      skid_sine <= res.sine;
      skid_last <= res.last;
    end
  end

endmodule

// ----- rtl/core/fm_sine_operator_unit.sv -----
// FM sine operator: per sample, phase = frac(frequency_ratio * sample_time *
// base_frequency) turns, plus mod_index * modulator_sample / (2*pi) when
// fm_enable is set, and sine_out is the Q1.15 sine of that phase, limited to
// +-32767. One item is accepted every cycle while the result channel keeps
// up. On its way an item passes four phase stages, one CORDIC stage per
// iteration up to the size of the angle table with folding and rounding
// stages around them, and the output register. Configuration takes effect
// for items accepted after the write. Depends on fmso_pkg, fmso_phase,
// fmso_cordic and fmso_skid.
module fm_sine_operator_unit
  import fmso_pkg::*;
#(
  parameter int SINE_ITERATIONS = SINE_ITERATIONS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [1:0]                 cfg_index,
  input  logic [23:0]                cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [31:0]                sample_time,
  input  logic [23:0]                base_frequency,
  input  logic signed [15:0]         modulator_sample,
  input  logic                       block_last,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] sine_out,
  output logic                       last_out
);

  fmso_cfg_t   cfg;
  fmso_phase_t phase_item;
  fmso_res_t   res;
  logic        held;
  logic        en;

  assign cfg_ready = 1'b1;
  assign en        = !held;
  assign in_ready  = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fm_enable       <= 1'b0;
      cfg.frequency_ratio <= 24'd65536;
      cfg.mod_index       <= 24'sd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FM_ENABLE:       cfg.fm_enable       <= cfg_data[0];
        REG_FREQUENCY_RATIO: cfg.frequency_ratio <= cfg_data;
        REG_MOD_INDEX:       cfg.mod_index       <= cfg_data;
        default: ;
      endcase
    end
  end

  fmso_phase u_phase (
    .clk              (clk),
    .rst              (rst),
    .en               (en),
    .cfg              (cfg),
    .in_valid         (in_valid),
    .sample_time      (sample_time),
    .base_frequency   (base_frequency),
    .modulator_sample (modulator_sample),
    .block_last       (block_last),
    .item             (phase_item)
  );

  fmso_cordic #(
    .ITERATIONS (SINE_ITERATIONS)
  ) u_cordic (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .item (phase_item),
    .res  (res)
  );

  fmso_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .res       (res),
    .out_ready (out_ready),
    .held      (held),
    .out_valid (out_valid),
    .sine_out  (sine_out),
    .last_out  (last_out)
  );

`ifndef SYNTHESIS
  // A held item always has a result ahead of it in the output register.
  a_held_has_output: assert property (@(posedge clk) disable iff (rst)
    held |-> out_valid)
    else $error("skid register full while the output register is empty");

  // A finished result that meets a stalled output must be caught.
  a_skid_catches: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready && !held && res.valid) |=> held)
    else $error("result lost while the output was stalled");

  // Once the output drains, the held item moves on and nothing new is held.
  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (held && out_ready) |=> !held)
    else $error("skid register did not drain");
`endif

endmodule

// ----- tb/tb_fm_sine_operator_unit.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for fm_sine_operator_unit: a directed table and random phases of
// samples, each checked against a typed value or a local sine predictor. Depends on fmso_pkg and the RTL.
module tb_fm_sine_operator_unit
  import fmso_pkg::*;
();

  localparam int CORDIC_STEPS     = 16;
  localparam int LATENCY          = CORDIC_STEPS + 7;
  localparam int WATCHDOG_LIMIT   = 2000;
  localparam int RANDOM_PHASES    = 12;
  localparam int ITEMS_PER_PHASE  = 140;
  localparam int DIRECTED_ROWS    = 29;

  localparam longint TURNS_PER_RADIAN_Q32 = 64'd683565276;
  localparam longint GAIN_Q30             = 64'sd652032874;

  localparam logic [31:0] TURN_ANGLES [24] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  typedef enum logic {ROW_ITEM = 1'b0, ROW_WRITE = 1'b1} row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    fmso_reg_t          index;
    logic [23:0]        data;
    logic [31:0]        t;
    logic [23:0]        f;
    logic signed [15:0] m;
    logic               last;
    logic               typed;
    logic signed [15:0] sine;
  } directed_row_t;

  typedef struct packed {
    logic signed [15:0] sine;
    logic               last;
  } sample_result_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [1:0]                 cfg_index = 2'd0;
  logic [23:0]                cfg_data = 24'd0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [31:0]                sample_time = 32'd0;
  logic [23:0]                base_frequency = 24'd0;
  logic signed [15:0]         modulator_sample = 16'sd0;
  logic                       block_last = 1'b0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] sine_out;
  logic                       last_out;

  // Expectation typed into the directed table travels with the item it belongs to.
  logic                       given_typed = 1'b0;
  logic signed [15:0]         given_sine = 16'sd0;

  logic                       model_fm = 1'b0;
  logic [23:0]                model_ratio = 24'h010000;
  logic signed [23:0]         model_index = 24'sd0;

  sample_result_t             pending_sines [$];
  sample_result_t             oldest;
  sample_result_t             fresh;
  int                         mismatches = 0;
  int                         quiet_cycles = 0;

  bit                         sender_idles = 1'b1;
  bit                         sink_stalls = 1'b1;
  int                         burst_left = 0;
  logic [15:0]                sink_pattern = 16'hFFFF;
  int                         pattern_pos = 0;

  localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{ROW_ITEM,  REG_FM_ENABLE,  24'h0, 32'h0000_0000, 24'h00_0000, 16'sh0000, 1'b0, 1'b0,
      16'sd0},
    // Quarter and three-quarter turn at reset settings: saturated peaks.
    '{ROW_ITEM,  REG_FM_ENABLE,  24'h0, 32'h0001_0000, 24'h00_0040, 16'sh8000, 1'b1, 1'b1,
      16'sd32767},
    '{ROW_ITEM,  REG_FM_ENABLE,  24'h0, 32'h0001_0000, 24'h00_00C0, 16'sh7FFF, 1'b0, 1'b1,
      -16'sd32767},
    '{ROW_ITEM,  REG_FM_ENABLE,  24'h0, 32'hFFFF_FFFF, 24'hFF_FFFF, 16'sh7FFF, 1'b1, 1'b0,
      16'sd0},
    // A ratio of one unit and a frequency of 1 Hz make the phase equal to sample_time.
    '{ROW_WRITE, REG_FREQUENCY_RATIO, 24'h000001, 32'h0, 24'h0, 16'sh0, 1'b0, 1'b0, 16'sd0},
    '{ROW_ITEM,  REG_FM_ENABLE,  24'h0, 32'h4000_0000, 24'h00_0100, 16'sh0000, 1'b0, 1'b1,
      16'sd32767},
    '{ROW_ITEM,  REG_FM_ENABLE,  24'h0, 32'h4000_0001, 24'h00_0100, 16'sh0000, 1'b1, 1'b0,
      16'sd0},
    '{ROW_ITEM,  REG_FM_ENABLE,  24'h0, 32'h7FFF_FFFF, 24'h00_0100, 16'sh0000, 1'b0, 1'b0,
      16'sd0},
    '{ROW_ITEM,  REG_FM_ENABLE,  24'h0, 32'h8000_0000, 24'h00_0100, 16'sh0000, 1'b1, 1'b0,
      16'sd0},
    '{ROW_ITEM,  REG_FM_ENABLE,  24'h0, 32'hBFFF_FFFF, 24'h00_0100, 16'sh0000, 1'b0, 1'b0,
      16'sd0},
    '{ROW_ITEM,  REG_FM_ENABLE,  24'h0, 32'hC000_0000, 24'h00_0100, 16'sh0000, 1'b0, 1'b1,
      -16'sd32767},
    '{ROW_ITEM,  REG_FM_ENABLE,  24'h0, 32'hC000_0001, 24'h00_0100, 16'sh0000, 1'b1, 1'b0,
      16'sd0},
    '{ROW_ITEM,  REG_FM_ENABLE,  24'h0, 32'hFFFF_FFFF, 24'h00_0100, 16'sh0000, 1'b0, 1'b0,
      16'sd0},
    // Modulator alone: the carrier is stopped by a zero ratio.
    '{ROW_WRITE, REG_FM_ENABLE,  24'hFFFFFF, 32'h0, 24'h0, 16'sh0, 1'b0, 1'b0, 16'sd0},
    '{ROW_WRITE, REG_FREQUENCY_RATIO, 24'h000000, 32'h0, 24'h0, 16'sh0, 1'b0, 1'b0, 16'sd0},
    '{ROW_WRITE, REG_MOD_INDEX,  24'h7FFFFF, 32'h0, 24'h0, 16'sh0, 1'b0, 1'b0, 16'sd0},
    '{ROW_ITEM,  REG_FM_ENABLE,  24'h0, 32'hFFFF_FFFF, 24'hFF_FFFF, 16'sh7FFF, 1'b0, 1'b0,
      16'sd0},
    '{ROW_ITEM,  REG_FM_ENABLE,  24'h0, 32'hFFFF_FFFF, 24'hFF_FFFF, 16'sh8000, 1'b1, 1'b0,
      16'sd0},
    '{ROW_ITEM,  REG_FM_ENABLE,  24'h0, 32'h0000_0000, 24'h00_0000, 16'sh0000, 1'b0, 1'b0,
      16'sd0},
    '{ROW_WRITE, REG_MOD_INDEX,  24'h800000, 32'h0, 24'h0, 16'sh0, 1'b0, 1'b0, 16'sd0},
    '{ROW_ITEM,  REG_FM_ENABLE,  24'h0, 32'h0000_0000, 24'h00_0000, 16'sh8000, 1'b0, 1'b0,
      16'sd0},
    '{ROW_ITEM,  REG_FM_ENABLE,  24'h0, 32'h0000_0000, 24'h00_0000, 16'sh7FFF, 1'b1, 1'b0,
      16'sd0},
    '{ROW_ITEM,  REG_FM_ENABLE,  24'h0, 32'h0000_0000, 24'h00_0000, 16'sh0001, 1'b0, 1'b0,
      16'sd0},
    // A write to the unused index must leave every register alone.
    '{ROW_WRITE, REG_UNUSED,     24'hFFFFFF, 32'h0, 24'h0, 16'sh0, 1'b0, 1'b0, 16'sd0},
    '{ROW_ITEM,  REG_FM_ENABLE,  24'h0, 32'h0000_0000, 24'h00_0000, 16'shFFFF, 1'b1, 1'b0,
      16'sd0},
    '{ROW_WRITE, REG_FREQUENCY_RATIO, 24'hFFFFFF, 32'h0, 24'h0, 16'sh0, 1'b0, 1'b0, 16'sd0},
    '{ROW_WRITE, REG_MOD_INDEX,  24'h010000, 32'h0, 24'h0, 16'sh0, 1'b0, 1'b0, 16'sd0},
    '{ROW_ITEM,  REG_FM_ENABLE,  24'h0, 32'hFFFF_FFFF, 24'hFF_FFFF, 16'sh7FFF, 1'b1, 1'b0,
      16'sd0},
    '{ROW_ITEM,  REG_FM_ENABLE,  24'h0, 32'h1234_5678, 24'h00_ABCD, 16'shCFC7, 1'b0, 1'b0,
      16'sd0}
  };

  fm_sine_operator_unit #(
    .SINE_ITERATIONS(CORDIC_STEPS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sample_time(sample_time),
    .base_frequency(base_frequency),
    .modulator_sample(modulator_sample),
    .block_last(block_last),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sine_out(sine_out),
    .last_out(last_out)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Sine of one sample under the current register settings.
  function automatic logic signed [15:0] operator_sine(input logic [31:0] t,
                                                        input logic [23:0] f,
                                                        input logic signed [15:0] m);
    logic [63:0] wide;
    logic [31:0] phase;
    logic [31:0] offset;
    logic [31:0] z;
    longint      product;
    longint      mag;
    longint      scaled;
    longint      x;
    longint      y;
    longint      dx;
    longint      dy;
    longint      r;
    bit          folded;
    int          steps;
    int          i;
    wide = {40'd0, model_ratio} * {32'd0, t};
    wide = {24'd0, wide[39:0]} * {40'd0, f};
    phase = wide[39:8];
    if (model_fm) begin
      product = longint'(model_index) * longint'(m);
      mag = (product < 0) ? -product : product;
      scaled = (mag >>> 16) * TURNS_PER_RADIAN_Q32
             + (((mag & 64'hFFFF) * TURNS_PER_RADIAN_Q32) >>> 16);
      offset = 32'(scaled >>> 15);
      if (product < 0) begin
        offset = 32'd0 - offset;
      end
      phase = phase + offset;
    end
    // Fold into the right half-plane so the rotation converges.
    folded = (phase > 32'h4000_0000) && (phase < 32'hC000_0000);
    z = folded ? phase - 32'h8000_0000 : phase;
    x = GAIN_Q30;
    y = 0;
    steps = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
    for (i = 0; i < steps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (!z[31]) begin
        x = x - dx;
        y = y + dy;
        z = z - TURN_ANGLES[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + TURN_ANGLES[i];
      end
    end
    r = (y + 64'sd16384) >>> 15;
    if (folded) begin
      r = -r;
    end
    if (r > 32767) begin
      r = 32767;
    end
    if (r < -32767) begin
      r = -32767;
    end
    return 16'(r);
  endfunction

  // Results are checked before new items are predicted, all on the same edge.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_sines.size() == 0) begin
          $error("sine_out: expected nothing, got %0d", sine_out);
          mismatches++;
        end else begin
          oldest = pending_sines.pop_front();
          if (sine_out !== oldest.sine) begin
            $error("sine_out: expected %0d, got %0d", oldest.sine, sine_out);
            mismatches++;
          end
          if (last_out !== oldest.last) begin
            $error("last_out: expected %0b, got %0b", oldest.last, last_out);
            mismatches++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FM_ENABLE:       model_fm = cfg_data[0];
          REG_FREQUENCY_RATIO: model_ratio = cfg_data;
          REG_MOD_INDEX:       model_index = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        fresh.last = block_last;
        fresh.sine = given_typed ? given_sine
                                 : operator_sine(sample_time, base_frequency, modulator_sample);
        pending_sines = {pending_sines, fresh};
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // The receiver walks a random 16-bit ready pattern, always with at least one ready slot.
  always @(negedge clk) begin
    if (pattern_pos == 15) begin
      sink_pattern = 16'($urandom) | (16'd1 << $urandom_range(0, 15));
      pattern_pos = 0;
    end else begin
      pattern_pos = pattern_pos + 1;
    end
    out_ready = !sink_stalls || sink_pattern[pattern_pos];
  end

  task automatic send_sample(input logic [31:0] t, input logic [23:0] f,
                             input logic signed [15:0] m, input logic l,
                             input logic typed, input logic signed [15:0] sine);
    int gap;
    @(negedge clk);
    in_valid = 1'b1;
    sample_time = t;
    base_frequency = f;
    modulator_sample = m;
    block_last = l;
    given_typed = typed;
    given_sine = sine;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (sender_idles) begin
      if (burst_left > 0) begin
        burst_left--;
      end
      if (burst_left == 0) begin
        gap = $urandom_range(1, 24);
        burst_left = $urandom_range(1, 40);
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  task automatic write_register(input fmso_reg_t idx, input logic [23:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Holds the sender until every outstanding item has come back, then lets the pipe empty.
  task automatic drain_pipeline();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_sines.size() != 0) @(negedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  initial begin
    int                 row;
    int                 phase_no;
    int                 k;
    int                 hold_at;
    logic [31:0]        t;
    logic [23:0]        f;
    logic signed [15:0] m;
    logic [23:0]        ratio;
    logic [23:0]        index;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (row = 0; row < DIRECTED_ROWS; row++) begin
      if (DIRECTED[row].kind == ROW_WRITE) begin
        if (row > 0 && DIRECTED[row - 1].kind == ROW_ITEM) begin
          drain_pipeline();
        end
        write_register(DIRECTED[row].index, DIRECTED[row].data);
      end else begin
        send_sample(DIRECTED[row].t, DIRECTED[row].f, DIRECTED[row].m, DIRECTED[row].last,
                    DIRECTED[row].typed, DIRECTED[row].sine);
      end
    end

    for (phase_no = 0; phase_no < RANDOM_PHASES; phase_no++) begin
      drain_pipeline();
      sender_idles = (phase_no % 3) != 2;
      sink_stalls = (phase_no % 4) != 1;
      case ($urandom_range(0, 4))
        0:       ratio = 24'h000000;
        1:       ratio = 24'hFFFFFF;
        2:       ratio = 24'h010000;
        3:       ratio = 24'($urandom_range(0, 24'h040000));
        default: ratio = 24'($urandom);
      endcase
      case ($urandom_range(0, 4))
        0:       index = 24'h800000;
        1:       index = 24'h7FFFFF;
        2:       index = 24'h000000;
        3:       index = 24'($urandom_range(0, 24'h080000)) - 24'h040000;
        default: index = 24'($urandom);
      endcase
      write_register(REG_FM_ENABLE, 24'($urandom));
      write_register(REG_FREQUENCY_RATIO, ratio);
      write_register(REG_MOD_INDEX, index);
      if ($urandom_range(0, 3) == 0) begin
        write_register(REG_UNUSED, 24'($urandom));
      end
      hold_at = $urandom_range(0, ITEMS_PER_PHASE - 1);
      for (k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (k == hold_at) begin
          drain_pipeline();
        end
        case ($urandom_range(0, 3))
          0:       t = $urandom_range(0, 32'h0004_0000);
          1:       t = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0000_0000;
          default: t = $urandom;
        endcase
        case ($urandom_range(0, 4))
          0:       f = 24'($urandom_range(20 * 256, 20000 * 256));
          1:       f = 24'($urandom_range(0, 2000 * 256));
          2:       f = ($urandom_range(0, 1) != 0) ? 24'hFF_FFFF : 24'h00_0000;
          default: f = 24'($urandom);
        endcase
        case ($urandom_range(0, 4))
          0:       m = 16'sh8000;
          1:       m = 16'sh7FFF;
          2:       m = 16'($urandom_range(0, 512)) - 16'sd256;
          default: m = 16'($urandom);
        endcase
        send_sample(t, f, m, $urandom_range(0, 15) == 0, 1'b0, 16'sd0);
      end
    end

    drain_pipeline();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
